// ----- hw/rtl/pcma_pkg.sv -----
// ----------------------------------------------------------------------------
// pcma_pkg
// Shared types and constants of the per-class moving average alert block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcma_pkg;

    // fixed field widths
    localparam int SCORE_W = 16;
    localparam int LABEL_W = 4;
    localparam int LEVEL_W = 2;
    localparam int CFG_W   = 5;
    localparam int CFG_IDX_W = 1;

    // Q1.15 one and default thresholds (0.6, 0.7, 0.8)
    localparam logic [SCORE_W-1:0] Q_ONE    = 16'd32768;
    localparam logic [SCORE_W-1:0] DEF_LOW  = 16'd19661;
    localparam logic [SCORE_W-1:0] DEF_MID  = 16'd22938;
    localparam logic [SCORE_W-1:0] DEF_HIGH = 16'd26214;

    // reset values of the configuration registers
    localparam logic [3:0] RST_ACTIVE = 4'd8;
    localparam logic [4:0] RST_WINDOW = 5'd16;

    // item kinds
    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_THRESH = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LABELS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 1'd1;

    // alert levels
    localparam logic [LEVEL_W-1:0] LVL_NONE      = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_SEEMS     = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_PRESENT   = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_ATTENTION = 2'd3;

    // the three thresholds of one label
    typedef struct packed {
        logic [SCORE_W-1:0] high;
        logic [SCORE_W-1:0] mid;
        logic [SCORE_W-1:0] low;
    } t_thr;

endpackage

`default_nettype wire

// ----- hw/rtl/pcma_div.sv -----
// ----------------------------------------------------------------------------
// pcma_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pcma_div #(
    parameter int NW = 21,
    parameter int DW = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_busy,
    output logic               o_done,
    output logic [NW-1:0]      o_quot
);

    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   trial;
    logic          fits;
    logic [DW:0]   diff;

    // shift in the next dividend bit and try a subtract
    assign trial = {r_rem, r_quo[NW-1]};
    assign fits  = (trial >= {1'b0, r_div});
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], fits};
            r_rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

// ----- hw/rtl/pcma_label_store.sv -----
// ----------------------------------------------------------------------------
// pcma_label_store
// Per-label state memory: ring position, fill count, sum and thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module pcma_label_store #(
    parameter int LABELS = 8,
    parameter int LW     = 3,
    parameter int PW     = 4,
    parameter int FW     = 5,
    parameter int SW     = 21
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_clear,
    input  wire logic            i_rd_en,
    input  wire logic [LW-1:0]   i_rd_addr,
    output logic [PW-1:0]        o_pos,
    output logic [FW-1:0]        o_fill,
    output logic [SW-1:0]        o_sum,
    output pcma_pkg::t_thr       o_thr,
    input  wire logic            i_wr_en,
    input  wire logic [LW-1:0]   i_wr_addr,
    input  wire logic [PW-1:0]   i_wr_pos,
    input  wire logic [FW-1:0]   i_wr_fill,
    input  wire logic [SW-1:0]   i_wr_sum,
    input  wire pcma_pkg::t_thr  i_wr_thr
);

    localparam int TW = 3 * pcma_pkg::SCORE_W;
    localparam int EW = PW + FW + SW + TW;

    logic [EW-1:0]     mem [LABELS];
    logic [EW-1:0]     r_q;
    logic              r_ring_ok;
    logic              r_thr_ok;
    logic [LABELS-1:0] r_ring_vld;
    logic [LABELS-1:0] r_thr_vld;

    pcma_pkg::t_thr    def_thr;

    // entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= {i_wr_pos, i_wr_fill, i_wr_sum, i_wr_thr};
        end
        if (i_rd_en) begin
            r_q <= mem[i_rd_addr];
        end
    end

    // valid bits: ring part cleared on window change, thresholds on reset only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_vld <= '0;
            r_thr_vld  <= '0;
            r_ring_ok  <= 1'b0;
            r_thr_ok   <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_ring_ok <= r_ring_vld[i_rd_addr];
                r_thr_ok  <= r_thr_vld[i_rd_addr];
            end
            if (i_clear) begin
                r_ring_vld <= '0;
            end else if (i_wr_en) begin
                r_ring_vld[i_wr_addr] <= 1'b1;
            end
            if (i_wr_en) begin
                r_thr_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign def_thr.low  = pcma_pkg::DEF_LOW;
    assign def_thr.mid  = pcma_pkg::DEF_MID;
    assign def_thr.high = pcma_pkg::DEF_HIGH;

    // entries never written read as their reset value
    assign o_pos  = r_ring_ok ? r_q[EW-1 -: PW] : '0;
    assign o_fill = r_ring_ok ? r_q[EW-PW-1 -: FW] : '0;
    assign o_sum  = r_ring_ok ? r_q[TW+SW-1 -: SW] : '0;
    assign o_thr  = r_thr_ok ? pcma_pkg::t_thr'(r_q[TW-1:0]) : def_thr;

endmodule

`default_nettype wire

// ----- hw/rtl/per_class_moving_average_alert.sv -----
// ----------------------------------------------------------------------------
// per_class_moving_average_alert
// Per-label ring of recent scores with running mean and three-level alert.
// Score words look up the label, update the ring and pass through the bit-serial
// divider over the SW-bit window sum before the result is loaded; threshold words
// and unknown labels skip the divider. One word at a time: input ready returns in
// the cycle after the result is loaded into the output.
// Reset (synchronous) restores the registers and marks every label entry as
// empty with default thresholds through valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module per_class_moving_average_alert #(
    parameter int MAX_LABELS = 8,
    parameter int MAX_WINDOW = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [71:0] i_s_axis_tdata,  // label[3:0], sample, low, mid, high
    input  wire logic        i_s_axis_tuser,  // func
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,  // average[15:0], level[17:16], accepted[18]
    // configuration
    input  wire logic                               i_cfg_we,
    input  wire logic [pcma_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [pcma_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int SCW  = pcma_pkg::SCORE_W;
    localparam int LW   = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam int PW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FW   = $clog2(MAX_WINDOW + 1);
    localparam int SW   = SCW + FW;
    localparam int DEPTH = MAX_LABELS * MAX_WINDOW;
    localparam int SAW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SCORE,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [3:0] r_active;
    logic [4:0] r_window;

    // latched item
    logic                r_func;
    logic [LW-1:0]       r_idx;
    logic                r_known;
    logic [SCW-1:0]      r_sample;
    pcma_pkg::t_thr      r_new_thr;
    logic [PW-1:0]       r_pos;
    logic [SAW-1:0]      r_slot;
    logic [SCW-1:0]      r_avg;
    logic                r_add;
    logic                r_acc;

    // output register
    logic                r_out_vld;
    logic [SCW-1:0]      r_out_avg;
    logic [1:0]          r_out_lvl;
    logic                r_out_acc;

    // score memory
    logic [SCW-1:0]      score_mem [DEPTH];
    logic [SCW-1:0]      r_score_q;

    // item fields
    logic [3:0]          in_label;
    logic [SCW-1:0]      in_sample;
    logic [SCW-1:0]      in_sample_sat;
    logic                in_known;
    logic                in_accept;

    // window and ring arithmetic
    logic [8:0]          w_big;
    logic [FW-1:0]       w_eff;
    logic [PW-1:0]       st_pos;
    logic [FW-1:0]       st_fill;
    logic [SW-1:0]       st_sum;
    pcma_pkg::t_thr      st_thr;
    logic [PW-1:0]       pos_eff;
    logic [SAW-1:0]      slot;
    logic                ascending;
    logic                ring_full;
    logic [SW-1:0]       new_sum;
    logic [FW-1:0]       new_fill;
    logic [FW-1:0]       pos_inc;
    logic [PW-1:0]       new_pos;
    logic [1:0]          level;

    // store control
    logic                st_rd_en;
    logic                st_wr_en;
    logic [PW-1:0]       st_wr_pos;
    logic [FW-1:0]       st_wr_fill;
    logic [SW-1:0]       st_wr_sum;
    pcma_pkg::t_thr      st_wr_thr;
    logic                cfg_clear;

    // divider
    logic                div_start;
    logic                div_busy;
    logic                div_done;
    logic [SW-1:0]       div_quot;

    // ---- input decode
    assign in_label  = i_s_axis_tdata[3:0];
    assign in_sample = i_s_axis_tdata[19:4];
    assign in_sample_sat = (in_sample > pcma_pkg::Q_ONE) ? pcma_pkg::Q_ONE : in_sample;
    assign in_known  = (in_label < r_active) && ({3'b000, in_label} < 7'(MAX_LABELS));
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);

    // effective window: 0 acts as 1, capped at MAX_WINDOW
    assign w_big = (r_window == 5'd0) ? 9'd1 :
                   ((9'(r_window) > 9'(MAX_WINDOW)) ? 9'(MAX_WINDOW) : 9'(r_window));
    assign w_eff = FW'(w_big);

    // ---- configuration port
    assign cfg_clear = i_cfg_we && (i_cfg_idx == pcma_pkg::REG_WINDOW_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= pcma_pkg::RST_ACTIVE;
            r_window <= pcma_pkg::RST_WINDOW;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcma_pkg::REG_ACTIVE_LABELS: r_active <= i_cfg_data[3:0];
                pcma_pkg::REG_WINDOW_SIZE:   r_window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- label lookup
    assign pos_eff   = (FW'(st_pos) >= w_eff) ? '0 : st_pos;
    assign slot      = SAW'(r_idx) * SAW'(MAX_WINDOW) + SAW'(pos_eff);
    assign ascending = (r_new_thr.low < r_new_thr.mid) && (r_new_thr.mid < r_new_thr.high);

    // ---- ring update
    assign ring_full = (st_fill >= w_eff);
    assign new_sum   = (ring_full ? (st_sum - SW'(r_score_q)) : st_sum) + SW'(r_sample);
    assign new_fill  = ring_full ? w_eff : (st_fill + 1'b1);
    assign pos_inc   = FW'(r_pos) + 1'b1;
    assign new_pos   = (pos_inc >= w_eff) ? '0 : PW'(pos_inc);

    assign st_rd_en  = in_accept && in_known;
    assign st_wr_en  = ((r_state == S_LOOK) && r_known && (r_func == pcma_pkg::FUNC_THRESH)
                        && ascending) || (r_state == S_SCORE);
    assign st_wr_pos  = (r_state == S_SCORE) ? new_pos  : st_pos;
    assign st_wr_fill = (r_state == S_SCORE) ? new_fill : st_fill;
    assign st_wr_sum  = (r_state == S_SCORE) ? new_sum  : st_sum;
    assign st_wr_thr  = (r_state == S_SCORE) ? st_thr   : r_new_thr;
    assign div_start  = (r_state == S_SCORE);

    pcma_label_store #(
        .LABELS (MAX_LABELS),
        .LW     (LW),
        .PW     (PW),
        .FW     (FW),
        .SW     (SW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (cfg_clear),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (LW'(in_label)),
        .o_pos     (st_pos),
        .o_fill    (st_fill),
        .o_sum     (st_sum),
        .o_thr     (st_thr),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_pos  (st_wr_pos),
        .i_wr_fill (st_wr_fill),
        .i_wr_sum  (st_wr_sum),
        .i_wr_thr  (st_wr_thr)
    );

    // score ring memory; a slot read is used only when the ring is full, and then it was written since the last clear
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCORE) begin
            score_mem[r_slot] <= r_sample;
        end
        if ((r_state == S_LOOK) && r_known && (r_func == pcma_pkg::FUNC_ADD)) begin
            r_score_q <= score_mem[slot];
        end
    end

    // ---- mean
    pcma_div #(
        .NW (SW),
        .DW (FW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (new_sum),
        .i_divisor  (new_fill),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // ---- alert level
    always_comb begin
        if (!r_add) begin
            level = pcma_pkg::LVL_NONE;
        end else if (r_avg > st_thr.high) begin
            level = pcma_pkg::LVL_ATTENTION;
        end else if (r_avg > st_thr.mid) begin
            level = pcma_pkg::LVL_PRESENT;
        end else if (r_avg > st_thr.low) begin
            level = pcma_pkg::LVL_SEEMS;
        end else begin
            level = pcma_pkg::LVL_NONE;
        end
    end

    // ---- sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            // load a new result, or drop the one just taken
            if ((r_state == S_DONE) && (!r_out_vld || i_m_axis_tready)) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (r_known && (r_func == pcma_pkg::FUNC_ADD)) begin
                        r_state <= S_SCORE;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SCORE: r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_vld || i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_func    <= i_s_axis_tuser;
                    r_idx     <= LW'(in_label);
                    r_known   <= in_known;
                    r_sample  <= in_sample_sat;
                    r_new_thr.low  <= i_s_axis_tdata[35:20];
                    r_new_thr.mid  <= i_s_axis_tdata[51:36];
                    r_new_thr.high <= i_s_axis_tdata[67:52];
                end
            end
            S_LOOK: begin
                r_pos  <= pos_eff;
                r_slot <= slot;
                r_avg  <= '0;
                r_add  <= 1'b0;
                r_acc  <= r_known && ((r_func == pcma_pkg::FUNC_ADD) || ascending);
            end
            S_DIV: begin
                if (div_done) begin
                    r_avg <= div_quot[SCW-1:0];
                    r_add <= 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    r_out_avg <= r_avg;
                    r_out_lvl <= level;
                    r_out_acc <= r_acc;
                end
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {5'b00000, r_out_acc, r_out_lvl, r_out_avg};

    // ---- checks
    a_ready_not_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !div_busy)
        else $error("input ready while the divider is busy");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside the done step");

    a_rejected_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[18]) |-> (o_m_axis_tdata[17:0] == 18'd0))
        else $error("rejected word carries a mean or level");

endmodule

`default_nettype wire
